// ===== hdl/aoast_pkg.sv =====
// package for the aged open-addressing slot table: payload types, codes and states
`timescale 1ns / 1ps

package aoast_pkg;

    localparam int unsigned SLOT_COUNT_DEF = 512;
    localparam int unsigned KEY_W          = 32;
    localparam int unsigned FRAME_W        = 32;
    localparam int unsigned SLOT_IDX_W     = 9;
    localparam int unsigned OUTCOME_W      = 3;

    localparam logic OP_GET  = 1'b0;
    localparam logic OP_PEEK = 1'b1;

    typedef enum logic [OUTCOME_W-1:0] {
        OUTCOME_HIT       = 3'd0,
        OUTCOME_CREATED   = 3'd1,
        OUTCOME_RECLAIMED = 3'd2,
        OUTCOME_CLOBBERED = 3'd3,
        OUTCOME_PEEK_MISS = 3'd4
    } outcome_t;

    typedef struct packed {
        logic               op;
        logic [KEY_W-1:0]   key_id;
        logic [FRAME_W-1:0] frame_number;
    } s_payload_t;

    typedef struct packed {
        logic [SLOT_IDX_W-1:0] slot_index;
        logic [OUTCOME_W-1:0]  outcome;
    } m_payload_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_START,
        ST_PROBE
    } state_t;

endpackage

// ===== hdl/aged_open_addressing_slot_table.sv =====
// top level: slot table with linear probing over one key/stamp memory
//
// channel  dir  handshake          payload
// s_       in   s_valid / s_ready  op, key_id, frame_number
// m_       out  m_valid / m_ready  slot_index, outcome
//
// one request at a time: accept, start the read of the home slot, then visit one slot after
// another until a hit, an empty slot or the last slot; one memory read per cycle sets the pace
// a table size that is not a power of two adds a hash step for the home bucket (4 key bits a cycle)
// after reset a clearing pass writes every slot, with s_ready low
// a finished result waits in the output register; a new request is taken meanwhile,
// and the probe holds on its last slot while the output register is still full
`timescale 1ns / 1ps

module aged_open_addressing_slot_table #(
    parameter int unsigned SLOT_COUNT = aoast_pkg::SLOT_COUNT_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  aoast_pkg::s_payload_t  s_payload,
    output logic                   m_valid,
    input  logic                   m_ready,
    output aoast_pkg::m_payload_t  m_payload
);
    import aoast_pkg::*;

    localparam int unsigned IDX_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int unsigned REM_W   = IDX_W + 4;
    localparam bit          IS_POW2 = (SLOT_COUNT & (SLOT_COUNT - 1)) == 0;
    localparam int unsigned ENTRY_W = KEY_W + FRAME_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
    localparam logic [REM_W-1:0] MOD_X1 = REM_W'(SLOT_COUNT);
    localparam logic [REM_W-1:0] MOD_X2 = REM_W'(2 * SLOT_COUNT);
    localparam logic [REM_W-1:0] MOD_X4 = REM_W'(4 * SLOT_COUNT);
    localparam logic [REM_W-1:0] MOD_X8 = REM_W'(8 * SLOT_COUNT);

    // key in the upper half, stamp in the lower half
    logic [ENTRY_W-1:0] mem [SLOT_COUNT];
    logic [ENTRY_W-1:0] mem_rdata_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [IDX_W-1:0]   mem_raddr;

    state_t             state_reg, state_next;
    logic               op_reg, op_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic [IDX_W-1:0]   home_reg, home_next;
    logic [IDX_W-1:0]   probe_idx_reg, probe_idx_next;
    logic [IDX_W-1:0]   probe_cnt_reg, probe_cnt_next;
    logic               have_cold_reg, have_cold_next;
    logic [IDX_W-1:0]   cold_idx_reg, cold_idx_next;
    logic [IDX_W-1:0]   rem_reg, rem_next;
    logic [2:0]         dig_reg, dig_next;
    logic               m_valid_reg, m_valid_next;
    m_payload_t         m_payload_reg, m_payload_next;

    logic               s_fire;
    logic [KEY_W-1:0]   key_in;
    logic [KEY_W-1:0]   slot_key;
    logic [FRAME_W-1:0] slot_stamp;
    logic               hit, empty, cold_here, last, fin, out_free, retire, advance;
    logic [IDX_W-1:0]   next_idx;
    logic [REM_W-1:0]   rem_s0, rem_s1, rem_s2, rem_s3, rem_s4;
    logic [IDX_W-1:0]   res_idx;
    outcome_t           res_outcome;
    logic               res_write;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign key_in    = (s_payload.key_id == '0) ? KEY_W'(1) : s_payload.key_id;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // probe evaluation on the slot read last cycle
    assign slot_key   = mem_rdata_reg[ENTRY_W-1:FRAME_W];
    assign slot_stamp = mem_rdata_reg[FRAME_W-1:0];
    assign hit        = (slot_key == key_reg);
    assign empty      = (slot_key == '0);
    assign cold_here  = (frame_reg - slot_stamp) > FRAME_W'(1);
    assign last       = (probe_cnt_reg == LAST_IDX);
    assign fin        = hit || empty || last;
    assign out_free   = !m_valid_reg || m_ready;
    assign retire     = (state_reg == ST_PROBE) && fin && out_free;
    assign advance    = (state_reg == ST_PROBE) && !fin;
    assign next_idx   = (probe_idx_reg == LAST_IDX) ? '0 : probe_idx_reg + IDX_W'(1);

    // home bucket, one key nibble per cycle
    always_comb begin
        rem_s0 = {rem_reg, key_reg[{dig_reg, 2'b00} +: 4]};
        rem_s1 = (rem_s0 >= MOD_X8) ? rem_s0 - MOD_X8 : rem_s0;
        rem_s2 = (rem_s1 >= MOD_X4) ? rem_s1 - MOD_X4 : rem_s1;
        rem_s3 = (rem_s2 >= MOD_X2) ? rem_s2 - MOD_X2 : rem_s2;
        rem_s4 = (rem_s3 >= MOD_X1) ? rem_s3 - MOD_X1 : rem_s3;
    end

    always_comb begin
        res_idx     = probe_idx_reg;
        res_outcome = OUTCOME_HIT;
        res_write   = 1'b0;
        priority if (hit) begin
            res_write = (op_reg == OP_GET);
        end else if (op_reg == OP_PEEK) begin
            res_idx     = '0;
            res_outcome = OUTCOME_PEEK_MISS;
        end else if (empty) begin
            res_write = 1'b1;
            if (have_cold_reg) begin
                res_idx     = cold_idx_reg;
                res_outcome = OUTCOME_RECLAIMED;
            end else begin
                res_outcome = OUTCOME_CREATED;
            end
        end else begin
            res_write = 1'b1;
            if (have_cold_reg) begin
                res_idx     = cold_idx_reg;
                res_outcome = OUTCOME_RECLAIMED;
            end else if (cold_here) begin
                res_outcome = OUTCOME_RECLAIMED;
            end else begin
                res_idx     = home_reg;
                res_outcome = OUTCOME_CLOBBERED;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (probe_idx_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = IS_POW2 ? ST_START : ST_HASH;
                end
            end
            ST_HASH: begin
                if (dig_reg == 3'd0) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                state_next = ST_PROBE;
            end
            ST_PROBE: begin
                if (retire) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        op_next        = op_reg;
        key_next       = key_reg;
        frame_next     = frame_reg;
        home_next      = home_reg;
        probe_idx_next = probe_idx_reg;
        probe_cnt_next = probe_cnt_reg;
        have_cold_next = have_cold_reg;
        cold_idx_next  = cold_idx_reg;
        rem_next       = rem_reg;
        dig_next       = dig_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_payload_next = m_payload_reg;
        mem_we         = 1'b0;
        mem_waddr      = probe_idx_reg;
        mem_wdata      = {key_reg, frame_reg};
        mem_raddr      = probe_idx_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we         = 1'b1;
                mem_wdata      = '0;
                probe_idx_next = next_idx;
            end
            ST_IDLE: begin
                if (s_fire) begin
                    op_next        = s_payload.op;
                    key_next       = key_in;
                    frame_next     = s_payload.frame_number;
                    home_next      = key_in[IDX_W-1:0];
                    rem_next       = '0;
                    dig_next       = 3'd7;
                    probe_cnt_next = '0;
                    have_cold_next = 1'b0;
                end
            end
            ST_HASH: begin
                rem_next  = rem_s4[IDX_W-1:0];
                home_next = rem_s4[IDX_W-1:0];
                dig_next  = dig_reg - 3'd1;
            end
            ST_START: begin
                mem_raddr      = home_reg;
                probe_idx_next = home_reg;
            end
            ST_PROBE: begin
                if (advance) begin
                    mem_raddr      = next_idx;
                    probe_idx_next = next_idx;
                    probe_cnt_next = probe_cnt_reg + IDX_W'(1);
                    if (!have_cold_reg && cold_here) begin
                        have_cold_next = 1'b1;
                        cold_idx_next  = probe_idx_reg;
                    end
                end
                if (retire) begin
                    mem_we                    = res_write;
                    mem_waddr                 = res_idx;
                    m_valid_next              = 1'b1;
                    m_payload_next.slot_index = SLOT_IDX_W'(res_idx);
                    m_payload_next.outcome    = res_outcome;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            probe_idx_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            probe_idx_reg <= probe_idx_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        frame_reg     <= frame_next;
        home_reg      <= home_next;
        probe_cnt_reg <= probe_cnt_next;
        have_cold_reg <= have_cold_next;
        cold_idx_reg  <= cold_idx_next;
        rem_reg       <= rem_next;
        dig_reg       <= dig_next;
        m_payload_reg <= m_payload_next;
    end

    a_peek_miss_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_payload_reg.outcome == OUTCOME_PEEK_MISS)
            |-> (m_payload_reg.slot_index == '0))
        else $error("peek miss with nonzero slot index");

    a_probe_write_only_on_retire: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PROBE) && mem_we |-> retire && (op_reg == OP_GET))
        else $error("table written during probe without a finished get");

    a_no_accept_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_ready)
        else $error("request accepted during clearing pass");

    a_result_from_probe: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_PROBE))
        else $error("result raised outside a probe");

endmodule

// ===== test/testbench.sv =====
// testbench for the aged slot table: directed aging cases, clustered random traffic, full table
`timescale 1ns / 1ps

module testbench;
    import aoast_pkg::*;

    localparam int unsigned SLOTS = SLOT_COUNT_DEF;
    localparam int POOL_SIZE = 96;
    localparam int STALL_LIMIT = 8000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 20;
    localparam int MAX_PRINTS = 30;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    s_payload_t s_payload = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    m_payload_t m_payload;

    logic [KEY_W-1:0]   slot_keys [SLOTS];
    logic [FRAME_W-1:0] slot_stamps [SLOTS];
    logic [KEY_W-1:0]   key_pool [POOL_SIZE];
    logic [FRAME_W-1:0] traffic_frame = '0;
    m_payload_t         pending_slots [$];

    int error_count = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int checked_count = 0;
    int outcome_seen [8] = '{default: 0};

    aged_open_addressing_slot_table #(
        .SLOT_COUNT(SLOTS)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // find or place the key, updating the local copy of the table
    function automatic m_payload_t lookup_slot(s_payload_t req);
        logic [KEY_W-1:0] key;
        int unsigned      home;
        int unsigned      idx;
        int unsigned      cold_idx;
        bit               have_cold;
        bit               have_empty;
        m_payload_t       res;
        key = (req.key_id == '0) ? KEY_W'(1) : req.key_id;
        home = key % SLOTS;
        idx = home;
        cold_idx = 0;
        have_cold = 1'b0;
        have_empty = 1'b0;
        for (int unsigned n = 0; n < SLOTS; n++) begin
            if (slot_keys[idx] == key) begin
                if (req.op == OP_GET) begin
                    slot_stamps[idx] = req.frame_number;
                end
                res.slot_index = SLOT_IDX_W'(idx);
                res.outcome = OUTCOME_HIT;
                return res;
            end
            if (slot_keys[idx] == '0) begin
                have_empty = 1'b1;
                break;
            end
            if (!have_cold && FRAME_W'(req.frame_number - slot_stamps[idx]) > 1) begin
                have_cold = 1'b1;
                cold_idx = idx;
            end
            idx = (idx + 1) % SLOTS;
        end
        if (req.op == OP_PEEK) begin
            res.slot_index = '0;
            res.outcome = OUTCOME_PEEK_MISS;
            return res;
        end
        if (have_cold) begin
            idx = cold_idx;
            res.outcome = OUTCOME_RECLAIMED;
        end else if (have_empty) begin
            res.outcome = OUTCOME_CREATED;
        end else begin
            idx = home;
            res.outcome = OUTCOME_CLOBBERED;
        end
        slot_keys[idx] = key;
        slot_stamps[idx] = req.frame_number;
        res.slot_index = SLOT_IDX_W'(idx);
        return res;
    endfunction

    task automatic flag_mismatch(string what);
        error_count++;
        if (error_count <= MAX_PRINTS) begin
            $display("mismatch at %0t: %s", $realtime, what);
        end
    endtask

    task automatic offer_request(logic op, logic [KEY_W-1:0] key, logic [FRAME_W-1:0] frame);
        s_payload_t req;
        req.op = op;
        req.key_id = key;
        req.frame_number = frame;
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= req;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_slots.size() != 0) @(posedge aclk);
    endtask

    // accepted request transactions
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            pending_slots.push_back(lookup_slot(s_payload));
        end
    end

    // result transactions against the oldest prediction
    always @(posedge aclk) begin : check_result
        m_payload_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_slots.size() == 0) begin
                flag_mismatch($sformatf("unexpected result slot %0d outcome %0d",
                                        m_payload.slot_index, m_payload.outcome));
            end else begin
                want = pending_slots.pop_front();
                checked_count++;
                outcome_seen[want.outcome]++;
                if (m_payload.slot_index !== want.slot_index) begin
                    flag_mismatch($sformatf("slot_index %0d, want %0d",
                                            m_payload.slot_index, want.slot_index));
                end
                if (m_payload.outcome !== want.outcome) begin
                    flag_mismatch($sformatf("outcome %0d, want %0d",
                                            m_payload.outcome, want.outcome));
                end
            end
        end
    end

    // receiver stalls, with an occasional long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", quiet_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic test_zero_key_and_extremes();
        idle_pct = 0;
        stall_pct = 0;
        offer_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
        offer_request(OP_PEEK, 32'h0000_0001, 32'h0000_0000);
        offer_request(OP_PEEK, 32'h0000_0000, 32'hFFFF_FFFF);
        offer_request(OP_PEEK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_request(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain_results();
    endtask

    task automatic test_wrapping_chain();
        idle_pct = 30;
        stall_pct = 30;
        offer_request(OP_GET, 32'h0000_01FF, 32'hFFFF_FFFF);
        offer_request(OP_GET, 32'h2000_01FF, 32'h0000_0000);
        offer_request(OP_PEEK, 32'h2000_01FF, 32'h0000_0000);
        offer_request(OP_PEEK, 32'h3000_01FF, 32'h0000_0000);
        drain_results();
    endtask

    task automatic test_aging_rules();
        idle_pct = 0;
        stall_pct = 0;
        offer_request(OP_GET, 32'hA000_01F0, 32'd10);
        offer_request(OP_GET, 32'hB000_01F0, 32'd10);
        // cold slot ahead of the key still gives a hit
        offer_request(OP_GET, 32'hB000_01F0, 32'd100);
        offer_request(OP_PEEK, 32'hA000_01F0, 32'd100);
        offer_request(OP_GET, 32'hA000_01F0, 32'd200);
        offer_request(OP_GET, 32'hC000_01F0, 32'd201);
        offer_request(OP_PEEK, 32'hB000_01F0, 32'd201);
        // frame going backwards
        offer_request(OP_GET, 32'hB000_01F0, 32'd5);
        offer_request(OP_PEEK, 32'hA000_01F0, 32'd5);
        // exactly two frames old
        offer_request(OP_GET, 32'hD000_01F0, 32'd7);
        offer_request(OP_GET, 32'hE000_01F0, 32'd8);
        drain_results();
    endtask

    task automatic test_back_pressure();
        idle_pct = 0;
        stall_pct = 0;
        hold_left = HOLD_CYCLES;
        for (int i = 0; i < 12; i++) begin
            offer_request((i % 3 == 2) ? OP_PEEK : OP_GET, $urandom, 32'd300 + i);
        end
        drain_results();
    endtask

    task automatic test_random_traffic(int count, int idle, int stall);
        idle_pct = idle;
        stall_pct = stall;
        traffic_frame = $urandom;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 10) begin
                offer_request(1'($urandom_range(1)), $urandom, $urandom);
            end else begin
                if ($urandom_range(99) < 25) begin
                    traffic_frame = traffic_frame + $urandom_range(3, 1);
                end else if ($urandom_range(99) < 2) begin
                    traffic_frame = traffic_frame - $urandom_range(4, 1);
                end
                offer_request(($urandom_range(99) < 30) ? OP_PEEK : OP_GET,
                              key_pool[$urandom_range(POOL_SIZE - 1)], traffic_frame);
            end
        end
        drain_results();
    endtask

    task automatic test_full_table();
        logic [FRAME_W-1:0] base_frame;
        base_frame = 32'h8000_0000;
        idle_pct = 30;
        stall_pct = 30;
        for (int i = 0; i < SLOTS; i++) begin
            offer_request(OP_GET, {14'h3C3C, 9'(i), 9'(i)}, base_frame);
        end
        for (int k = 0; k < 3; k++) begin
            offer_request(OP_GET, {14'h1234, 9'(k), 9'(k * 37)}, base_frame + 1);
        end
        offer_request(OP_PEEK, 32'h0BAD_0042, base_frame);
        offer_request(OP_PEEK, {14'h3C3C, 9'd7, 9'd7}, base_frame);
        offer_request(OP_GET, 32'h5555_0100, base_frame + 2);
        offer_request(OP_GET, 32'h6666_0100, base_frame - 3);
        drain_results();
    endtask

    initial begin
        int unsigned pool_base;
        for (int i = 0; i < SLOTS; i++) begin
            slot_keys[i] = '0;
            slot_stamps[i] = '0;
        end
        // clustered homes so chains grow and merge
        pool_base = $urandom_range(SLOTS - 1);
        for (int j = 0; j < POOL_SIZE; j++) begin
            key_pool[j] = {23'($urandom), 9'((pool_base + (j % 8) * 5) % SLOTS)};
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_zero_key_and_extremes();
        test_wrapping_chain();
        test_aging_rules();
        test_back_pressure();
        test_random_traffic(180, 0, 0);
        test_random_traffic(180, 61, 0);
        test_random_traffic(180, 0, 61);
        test_random_traffic(180, 30, 30);
        test_full_table();

        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("checked %0d results: %0d hit, %0d created, %0d reclaimed, %0d clobbered, %s",
                 checked_count, outcome_seen[OUTCOME_HIT], outcome_seen[OUTCOME_CREATED],
                 outcome_seen[OUTCOME_RECLAIMED], outcome_seen[OUTCOME_CLOBBERED],
                 $sformatf("%0d peek miss", outcome_seen[OUTCOME_PEEK_MISS]));
        $display("traffic ran under four idle/stall mixes, a %0d-cycle receiver %s",
                 HOLD_CYCLES, "hold-off and a full table");
        if (error_count == 0 && pending_slots.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
